@@ hw/rtl/assert_macros.svh @@
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define HEL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define HEL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/hel_pkg.sv @@
package hel_pkg;

    typedef struct packed {
        logic [31:0] file_word;
        logic        end_of_file;
    } in_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] target_address;
        logic [31:0] payload;
        logic [3:0]  error_code;
        logic [6:0]  hunk_number;
    } out_t;

    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_STORE = 3'd1;
    localparam logic [2:0] ACT_FILL  = 3'd2;
    localparam logic [2:0] ACT_RELOC = 3'd3;
    localparam logic [2:0] ACT_DONE  = 3'd4;
    localparam logic [2:0] ACT_ERROR = 3'd5;

    localparam logic [3:0] ERR_OK          = 4'd0;
    localparam logic [3:0] ERR_BAD_MAGIC   = 4'd1;
    localparam logic [3:0] ERR_NAMES       = 4'd2;
    localparam logic [3:0] ERR_BAD_TABLE   = 4'd3;
    localparam logic [3:0] ERR_ALLOC_FLAG  = 4'd4;
    localparam logic [3:0] ERR_UNKNOWN     = 4'd5;
    localparam logic [3:0] ERR_PREMATURE   = 4'd6;
    localparam logic [3:0] ERR_MISMATCH    = 4'd7;
    localparam logic [3:0] ERR_TRUNCATED   = 4'd8;
    localparam logic [3:0] ERR_RELOC_RANGE = 4'd9;

    localparam logic [31:0] ID_HEADER  = 32'h0000_03F3;
    localparam logic [29:0] ID_CODE    = 30'h3E9;
    localparam logic [29:0] ID_DATA    = 30'h3EA;
    localparam logic [29:0] ID_BSS     = 30'h3EB;
    localparam logic [29:0] ID_RELOC32 = 30'h3EC;
    localparam logic [29:0] ID_END     = 30'h3F2;

    localparam logic REG_LOAD_BASE    = 1'b0;
    localparam logic REG_RELOC_ENABLE = 1'b1;

    typedef enum logic [3:0] {
        PH_MAGIC, PH_NAMES, PH_TSIZE, PH_FIRST, PH_LAST, PH_SIZES, PH_BLOCK,
        PH_CDLEN, PH_BSSLEN, PH_DATA, PH_RCOUNT, PH_RID, PH_ROFF, PH_HALT
    } phase_t;

    // What the emit stage does with the table word read for this beat.
    typedef enum logic [2:0] {
        K_NONE, K_STORE, K_FILL, K_RELOC, K_DONE, K_ERROR, K_ADDEND
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] word;
        logic [31:0] extra;
        logic [3:0]  code;
        logic [6:0]  hunk;
    } cmd_t;

endpackage

@@ hw/rtl/hel_table.sv @@
module hel_table #(
    parameter int DEPTH = 65,
    parameter int AW    = 7
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/hel_parse.sv @@
module hel_parse #(
    parameter int MAX_HUNKS = 64,
    parameter int HW        = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             write_enable,
    input  logic             reg_index,
    input  logic [31:0]      write_data,
    input  logic             fire,
    input  hel_pkg::in_t     item,
    output logic             mem_we,
    output logic [HW-1:0]    mem_waddr,
    output logic [31:0]      mem_wdata,
    output logic [HW-1:0]    mem_raddr,
    output hel_pkg::cmd_t    cmd
);

    hel_pkg::phase_t phase_reg, phase_next, step_phase;
    logic [HW-1:0] total_reg, total_next;
    logic [HW-1:0] fill_reg, fill_next;
    logic [HW-1:0] cur_reg, cur_next;
    logic          seen_reg, seen_next;
    logic [31:0]   remain_reg, remain_next;
    logic [31:0]   offset_reg, offset_next;
    logic [31:0]   sum_reg, sum_next;
    logic [31:0]   base_reg, base_next;
    logic [31:0]   load_base_reg;
    logic          reloc_en_reg;

    logic [31:0] w;
    logic [29:0] id;
    logic        eof;
    logic [3:0]  step_code, fin_code;
    logic        done;
    logic        last_ok, sizes_ok, rid_ok;
    logic        payload_id;
    logic [HW:0] hunk_step;
    logic [31:0] sum_add;

    assign w          = item.file_word;
    assign eof        = item.end_of_file;
    assign id         = w[29:0];
    assign payload_id = (id == hel_pkg::ID_CODE) || (id == hel_pkg::ID_DATA) ||
                        (id == hel_pkg::ID_BSS);
    assign hunk_step  = {1'b0, cur_reg} + {{HW{1'b0}}, seen_reg};
    assign last_ok    = !seen_reg && (remain_reg == w + 32'd1) &&
                        (w < 32'(MAX_HUNKS));
    assign sizes_ok   = (w[31:30] != 2'b11) && (fill_reg < total_reg) &&
                        ({1'b0, fill_reg} < (HW+1)'(MAX_HUNKS));
    assign rid_ok     = (w < 32'(total_reg)) && (cur_reg < total_reg);
    assign sum_add    = sum_reg + {w[29:0], 2'b00};

    // Hunk position tracking.
    always_comb
    begin
        cur_next  = cur_reg;
        seen_next = seen_reg;
        case (phase_reg)
            hel_pkg::PH_FIRST:
            begin
                seen_next = (w != 32'd0);
            end
            hel_pkg::PH_LAST:
            begin
                if (last_ok)
                begin
                    seen_next = 1'b0;
                end
            end
            hel_pkg::PH_SIZES:
            begin
                if (sizes_ok && ({1'b0, fill_reg} + 1'b1 >= {1'b0, total_reg}))
                begin
                    cur_next  = '0;
                    seen_next = 1'b0;
                end
            end
            hel_pkg::PH_BLOCK:
            begin
                if (payload_id && (hunk_step < {1'b0, total_reg}))
                begin
                    cur_next  = hunk_step[HW-1:0];
                    seen_next = 1'b1;
                end
                else if ((id == hel_pkg::ID_END) && seen_reg)
                begin
                    cur_next  = cur_reg + 1'b1;
                    seen_next = 1'b0;
                end
            end
            default:
            begin
                cur_next = cur_reg;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        step_phase = phase_reg;
        step_code  = hel_pkg::ERR_OK;
        case (phase_reg)
            hel_pkg::PH_MAGIC:
            begin
                if (w != hel_pkg::ID_HEADER) step_code = hel_pkg::ERR_BAD_MAGIC;
                else step_phase = hel_pkg::PH_NAMES;
            end
            hel_pkg::PH_NAMES:
            begin
                if (w != 32'd0) step_code = hel_pkg::ERR_NAMES;
                else step_phase = hel_pkg::PH_TSIZE;
            end
            hel_pkg::PH_TSIZE:  step_phase = hel_pkg::PH_FIRST;
            hel_pkg::PH_FIRST:  step_phase = hel_pkg::PH_LAST;
            hel_pkg::PH_LAST:
            begin
                if (!last_ok) step_code = hel_pkg::ERR_BAD_TABLE;
                else step_phase = hel_pkg::PH_SIZES;
            end
            hel_pkg::PH_SIZES:
            begin
                if (w[31:30] == 2'b11) step_code = hel_pkg::ERR_ALLOC_FLAG;
                else if (!sizes_ok) step_code = hel_pkg::ERR_BAD_TABLE;
                else if ({1'b0, fill_reg} + 1'b1 >= {1'b0, total_reg})
                    step_phase = hel_pkg::PH_BLOCK;
            end
            hel_pkg::PH_BLOCK:
            begin
                if (payload_id)
                begin
                    if (hunk_step >= {1'b0, total_reg}) step_code = hel_pkg::ERR_MISMATCH;
                    else if (id == hel_pkg::ID_BSS) step_phase = hel_pkg::PH_BSSLEN;
                    else step_phase = hel_pkg::PH_CDLEN;
                end
                else if (id == hel_pkg::ID_RELOC32) step_phase = hel_pkg::PH_RCOUNT;
                else if (id == hel_pkg::ID_END)
                begin
                    if (!seen_reg) step_code = hel_pkg::ERR_PREMATURE;
                end
                else step_code = hel_pkg::ERR_UNKNOWN;
            end
            hel_pkg::PH_CDLEN:
            begin
                step_phase = (w == 32'd0) ? hel_pkg::PH_BLOCK : hel_pkg::PH_DATA;
            end
            hel_pkg::PH_BSSLEN: step_phase = hel_pkg::PH_BLOCK;
            hel_pkg::PH_DATA:
            begin
                if (remain_reg == 32'd1) step_phase = hel_pkg::PH_BLOCK;
            end
            hel_pkg::PH_RCOUNT:
            begin
                step_phase = (w == 32'd0) ? hel_pkg::PH_BLOCK : hel_pkg::PH_RID;
            end
            hel_pkg::PH_RID:
            begin
                if (!rid_ok) step_code = hel_pkg::ERR_RELOC_RANGE;
                else step_phase = hel_pkg::PH_ROFF;
            end
            hel_pkg::PH_ROFF:
            begin
                if (remain_reg == 32'd1) step_phase = hel_pkg::PH_RCOUNT;
            end
            default: step_phase = hel_pkg::PH_HALT;
        endcase

        // The marked last word settles the outcome.
        fin_code = step_code;
        done     = 1'b0;
        if ((phase_reg != hel_pkg::PH_HALT) && (step_code == hel_pkg::ERR_OK) && eof)
        begin
            if ((step_phase == hel_pkg::PH_BLOCK) && (cur_next == total_reg) && !seen_next)
                done = 1'b1;
            else if (step_phase == hel_pkg::PH_BLOCK)
                fin_code = hel_pkg::ERR_MISMATCH;
            else
                fin_code = hel_pkg::ERR_TRUNCATED;
        end
        phase_next = step_phase;
        if (done || (fin_code != hel_pkg::ERR_OK))
            phase_next = hel_pkg::PH_HALT;
    end

    // Datapath registers, table writes and the command for the emit stage.
    always_comb
    begin
        total_next  = total_reg;
        fill_next   = fill_reg;
        remain_next = remain_reg;
        offset_next = offset_reg;
        sum_next    = sum_reg;
        base_next   = base_reg;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = load_base_reg;
        mem_raddr   = cur_reg;
        cmd.kind    = hel_pkg::K_NONE;
        cmd.word    = w;
        cmd.extra   = offset_reg;
        cmd.code    = fin_code;
        cmd.hunk    = 7'(cur_next);
        case (phase_reg)
            hel_pkg::PH_TSIZE: remain_next = w;
            hel_pkg::PH_LAST:
            begin
                if (last_ok)
                begin
                    total_next  = HW'(w) + 1'b1;
                    fill_next   = '0;
                    remain_next = 32'd0;
                    sum_next    = load_base_reg;
                    base_next   = load_base_reg;
                    mem_we      = fire;
                end
            end
            hel_pkg::PH_SIZES:
            begin
                if (sizes_ok)
                begin
                    fill_next = fill_reg + 1'b1;
                    sum_next  = sum_add;
                    mem_we    = fire;
                    mem_waddr = fill_reg + 1'b1;
                    mem_wdata = sum_add;
                end
            end
            hel_pkg::PH_CDLEN:
            begin
                remain_next = w;
                offset_next = 32'd0;
            end
            hel_pkg::PH_BSSLEN: cmd.kind = hel_pkg::K_FILL;
            hel_pkg::PH_DATA:
            begin
                cmd.kind    = hel_pkg::K_STORE;
                offset_next = offset_reg + 32'd4;
                remain_next = remain_reg - 32'd1;
            end
            hel_pkg::PH_RCOUNT:
            begin
                if (w != 32'd0) remain_next = w;
            end
            hel_pkg::PH_RID:
            begin
                mem_raddr = w[HW-1:0];
                cmd.kind  = hel_pkg::K_ADDEND;
            end
            hel_pkg::PH_ROFF:
            begin
                cmd.kind    = reloc_en_reg ? hel_pkg::K_RELOC : hel_pkg::K_NONE;
                remain_next = remain_reg - 32'd1;
            end
            default: cmd.kind = hel_pkg::K_NONE;
        endcase
        if (phase_reg == hel_pkg::PH_HALT)
        begin
            cmd.kind = hel_pkg::K_NONE;
        end
        else if (fin_code != hel_pkg::ERR_OK)
        begin
            cmd.kind = hel_pkg::K_ERROR;
        end
        else if (done)
        begin
            cmd.kind  = hel_pkg::K_DONE;
            cmd.extra = base_reg;
            cmd.word  = sum_reg - base_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= hel_pkg::PH_MAGIC;
            total_reg     <= '0;
            fill_reg      <= '0;
            cur_reg       <= '0;
            seen_reg      <= 1'b0;
            remain_reg    <= '0;
            offset_reg    <= '0;
            sum_reg       <= '0;
            base_reg      <= '0;
            load_base_reg <= '0;
            reloc_en_reg  <= 1'b0;
        end
        else
        begin
            if (write_enable)
            begin
                if (reg_index == hel_pkg::REG_LOAD_BASE) load_base_reg <= write_data;
                if (reg_index == hel_pkg::REG_RELOC_ENABLE) reloc_en_reg <= write_data[0];
            end
            if (fire)
            begin
                phase_reg  <= phase_next;
                total_reg  <= total_next;
                fill_reg   <= fill_next;
                cur_reg    <= cur_next;
                seen_reg   <= seen_next;
                remain_reg <= remain_next;
                offset_reg <= offset_next;
                sum_reg    <= sum_next;
                base_reg   <= base_next;
            end
        end
    end

endmodule

@@ hw/rtl/hel_emit.sv @@
module hel_emit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  hel_pkg::cmd_t cmd,
    input  logic [31:0]   rdata,
    output logic          busy,
    output logic          result_valid,
    input  logic          result_stall,
    output hel_pkg::out_t result
);

    logic          s1_valid_reg;
    hel_pkg::cmd_t s1_cmd_reg;
    logic          res_valid_reg;
    hel_pkg::out_t res_reg, res_next;
    logic [31:0]   addend_reg;
    logic          s1_adv;

    assign s1_adv = s1_valid_reg && (!res_valid_reg || !result_stall);
    assign busy   = s1_valid_reg && !s1_adv;

    always_comb
    begin
        res_next.action         = hel_pkg::ACT_NONE;
        res_next.target_address = 32'd0;
        res_next.payload        = 32'd0;
        res_next.error_code     = hel_pkg::ERR_OK;
        res_next.hunk_number    = s1_cmd_reg.hunk;
        case (s1_cmd_reg.kind)
            hel_pkg::K_STORE:
            begin
                res_next.action         = hel_pkg::ACT_STORE;
                res_next.target_address = rdata + s1_cmd_reg.extra;
                res_next.payload        = s1_cmd_reg.word;
            end
            hel_pkg::K_FILL:
            begin
                res_next.action         = hel_pkg::ACT_FILL;
                res_next.target_address = rdata;
                res_next.payload        = s1_cmd_reg.word;
            end
            hel_pkg::K_RELOC:
            begin
                res_next.action         = hel_pkg::ACT_RELOC;
                res_next.target_address = rdata + s1_cmd_reg.word;
                res_next.payload        = addend_reg;
            end
            hel_pkg::K_DONE:
            begin
                res_next.action         = hel_pkg::ACT_DONE;
                res_next.target_address = s1_cmd_reg.extra;
                res_next.payload        = s1_cmd_reg.word;
            end
            hel_pkg::K_ERROR:
            begin
                res_next.action     = hel_pkg::ACT_ERROR;
                res_next.error_code = s1_cmd_reg.code;
            end
            default: res_next.action = hel_pkg::ACT_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire) s1_valid_reg <= 1'b1;
            else if (s1_adv) s1_valid_reg <= 1'b0;
            if (s1_adv) res_valid_reg <= 1'b1;
            else if (!result_stall) res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire) s1_cmd_reg <= cmd;
        if (s1_adv)
        begin
            res_reg <= res_next;
            // table word read for a reloc target hunk
            if (s1_cmd_reg.kind == hel_pkg::K_ADDEND) addend_reg <= rdata;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

@@ hw/rtl/hunk_executable_loader.sv @@
// Pipeline: an accepted word's command and table read are registered, then the output
// register takes its result beat unless it is full and stalled. Throughput: one word per
// cycle while the output is not stalled; each word does one table read, one add and a
// phase update. The hunk table is one synchronous RAM, one write and one read port.
// Reset: rst_n async active low; back to header magic, parser registers and valid
// flags cleared, the table holds garbage until the header fills it. No clearing pass.
module hunk_executable_loader #(
    parameter int MAX_HUNKS = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          write_enable,
    input  logic          reg_index,
    input  logic [31:0]   write_data,
    input  logic          item_valid,
    output logic          item_stall,
    input  hel_pkg::in_t  item,
    output logic          result_valid,
    input  logic          result_stall,
    output hel_pkg::out_t result
);

    localparam int DEPTH = MAX_HUNKS + 1;
    localparam int HW    = $clog2(DEPTH);

    logic          fire;
    logic          busy;
    logic          mem_we;
    logic [HW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic [HW-1:0] mem_raddr;
    logic [31:0]   mem_rdata;
    hel_pkg::cmd_t cmd;

    assign item_stall = busy;
    assign fire       = item_valid && !busy;

    hel_parse #(.MAX_HUNKS(MAX_HUNKS), .HW(HW)) u_parse (
        .clk(clk), .rst_n(rst_n),
        .write_enable(write_enable), .reg_index(reg_index), .write_data(write_data),
        .fire(fire), .item(item),
        .mem_we(mem_we), .mem_waddr(mem_waddr), .mem_wdata(mem_wdata),
        .mem_raddr(mem_raddr), .cmd(cmd)
    );

    hel_table #(.DEPTH(DEPTH), .AW(HW)) u_table (
        .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
        .re(fire), .raddr(mem_raddr), .rdata(mem_rdata)
    );

    hel_emit u_emit (
        .clk(clk), .rst_n(rst_n), .fire(fire), .cmd(cmd), .rdata(mem_rdata),
        .busy(busy), .result_valid(result_valid), .result_stall(result_stall),
        .result(result)
    );

endmodule

@@ hw/rtl/hel_checker.sv @@
`include "assert_macros.svh"

module hel_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          item_stall,
    input logic          result_valid,
    input logic          result_stall,
    input hel_pkg::out_t result
);

    logic is_err;
    logic is_none;

    assign is_err  = result.action == hel_pkg::ACT_ERROR;
    assign is_none = result.action == hel_pkg::ACT_NONE;

    `HEL_ASSERT_NOW(a_err_code, clk, rst_n, result_valid && is_err, result.error_code != hel_pkg::ERR_OK)
    `HEL_ASSERT_NOW(a_ok_code, clk, rst_n, result_valid && !is_err, result.error_code == hel_pkg::ERR_OK)
    `HEL_ASSERT_NOW(a_none_zero, clk, rst_n, result_valid && (is_none || is_err), (result.target_address == 32'd0) && (result.payload == 32'd0))
    `HEL_ASSERT_NEXT(a_res_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(result))
    // input only backs up behind a full, stalled output register
    `HEL_ASSERT_NOW(a_stall_cause, clk, rst_n, item_stall, result_valid && result_stall)

endmodule

bind hunk_executable_loader hel_checker u_chk (.*);

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam int HUNKS = 64;
    localparam int WD_LIMIT = 5000;

    typedef struct {
        logic [31:0]   word;
        logic          eof;
        logic          typed;
        hel_pkg::out_t want;
    } row_t;

    logic          clk;
    logic          rst_n;
    logic          write_enable;
    logic          reg_index;
    logic [31:0]   write_data;
    logic          item_valid;
    logic          item_stall;
    hel_pkg::in_t  item;
    logic          result_valid;
    logic          result_stall;
    hel_pkg::out_t result;

    hunk_executable_loader u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .write_enable (write_enable),
        .reg_index    (reg_index),
        .write_data   (write_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // shadow of the loader
    logic [31:0]     base_reg;
    logic            reloc_on;
    hel_pkg::phase_t phase;
    logic [31:0]     hunk_addr [0:HUNKS];
    logic [6:0]      total_hunks;
    logic [6:0]      fill_idx;
    logic [6:0]      cur_hunk;
    logic            seen;
    logic [31:0]     words_left;
    logic [31:0]     store_ptr;
    logic [31:0]     addend;

    hel_pkg::out_t   pending_cmds[$];
    int              fails = 0;
    bit              quiet;
    bit              hold_req;
    bit              hold_done;
    int              idle_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic hel_pkg::out_t next_command(logic [31:0] w, logic eof);
        hel_pkg::out_t o;
        logic [3:0]    code;
        logic [29:0]   id;
        logic [6:0]    nxt;
        o = '0;
        code = hel_pkg::ERR_OK;
        if (phase == hel_pkg::PH_HALT)
        begin
            o.hunk_number = cur_hunk;
            return o;
        end
        case (phase)
            hel_pkg::PH_MAGIC:
                if (w != hel_pkg::ID_HEADER) code = hel_pkg::ERR_BAD_MAGIC;
                else phase = hel_pkg::PH_NAMES;
            hel_pkg::PH_NAMES:
                if (w != 0) code = hel_pkg::ERR_NAMES; else phase = hel_pkg::PH_TSIZE;
            hel_pkg::PH_TSIZE:
            begin
                words_left = w;
                phase = hel_pkg::PH_FIRST;
            end
            hel_pkg::PH_FIRST:
            begin
                seen = (w != 0);
                phase = hel_pkg::PH_LAST;
            end
            hel_pkg::PH_LAST:
                if (seen || words_left != w + 1 || w >= HUNKS)
                    code = hel_pkg::ERR_BAD_TABLE;
                else
                begin
                    total_hunks = w[6:0] + 7'd1;
                    hunk_addr[0] = base_reg;
                    fill_idx = 0;
                    seen = 0;
                    words_left = 0;
                    phase = hel_pkg::PH_SIZES;
                end
            hel_pkg::PH_SIZES:
                if (w[31:30] == 2'b11)
                    code = hel_pkg::ERR_ALLOC_FLAG;
                else if (fill_idx < total_hunks && fill_idx < HUNKS)
                begin
                    hunk_addr[fill_idx + 1] = hunk_addr[fill_idx] + {w[29:0], 2'b00};
                    fill_idx++;
                    if (fill_idx >= total_hunks)
                    begin
                        cur_hunk = 0;
                        seen = 0;
                        phase = hel_pkg::PH_BLOCK;
                    end
                end
                else
                    code = hel_pkg::ERR_BAD_TABLE;
            hel_pkg::PH_BLOCK:
            begin
                id = w[29:0];
                if (id == hel_pkg::ID_CODE || id == hel_pkg::ID_DATA ||
                    id == hel_pkg::ID_BSS)
                begin
                    nxt = cur_hunk + seen;
                    if (nxt >= total_hunks)
                        code = hel_pkg::ERR_MISMATCH;
                    else
                    begin
                        cur_hunk = nxt;
                        seen = 1;
                        phase = (id == hel_pkg::ID_BSS) ? hel_pkg::PH_BSSLEN
                                                        : hel_pkg::PH_CDLEN;
                    end
                end
                else if (id == hel_pkg::ID_RELOC32)
                    phase = hel_pkg::PH_RCOUNT;
                else if (id == hel_pkg::ID_END)
                begin
                    if (!seen)
                        code = hel_pkg::ERR_PREMATURE;
                    else
                    begin
                        cur_hunk++;
                        seen = 0;
                    end
                end
                else
                    code = hel_pkg::ERR_UNKNOWN;
            end
            hel_pkg::PH_CDLEN:
            begin
                words_left = w;
                store_ptr = hunk_addr[cur_hunk];
                phase = (w == 0) ? hel_pkg::PH_BLOCK : hel_pkg::PH_DATA;
            end
            hel_pkg::PH_BSSLEN:
            begin
                o.action = hel_pkg::ACT_FILL;
                o.target_address = hunk_addr[cur_hunk];
                o.payload = w;
                phase = hel_pkg::PH_BLOCK;
            end
            hel_pkg::PH_DATA:
            begin
                o.action = hel_pkg::ACT_STORE;
                o.target_address = store_ptr;
                o.payload = w;
                store_ptr += 4;
                words_left--;
                if (words_left == 0) phase = hel_pkg::PH_BLOCK;
            end
            hel_pkg::PH_RCOUNT:
                if (w == 0)
                    phase = hel_pkg::PH_BLOCK;
                else
                begin
                    words_left = w;
                    phase = hel_pkg::PH_RID;
                end
            hel_pkg::PH_RID:
                if (w >= total_hunks || cur_hunk >= total_hunks)
                    code = hel_pkg::ERR_RELOC_RANGE;
                else
                begin
                    addend = hunk_addr[w[6:0]];
                    phase = hel_pkg::PH_ROFF;
                end
            hel_pkg::PH_ROFF:
            begin
                if (reloc_on)
                begin
                    o.action = hel_pkg::ACT_RELOC;
                    o.target_address = hunk_addr[cur_hunk] + w;
                    o.payload = addend;
                end
                words_left--;
                if (words_left == 0) phase = hel_pkg::PH_RCOUNT;
            end
            default:
                phase = hel_pkg::PH_HALT;
        endcase
        if (code == hel_pkg::ERR_OK && eof)
        begin
            if (phase == hel_pkg::PH_BLOCK && cur_hunk == total_hunks && !seen)
            begin
                o.action = hel_pkg::ACT_DONE;
                o.target_address = hunk_addr[0];
                o.payload = hunk_addr[total_hunks] - hunk_addr[0];
                phase = hel_pkg::PH_HALT;
            end
            else
                code = (phase == hel_pkg::PH_BLOCK) ? hel_pkg::ERR_MISMATCH
                                                    : hel_pkg::ERR_TRUNCATED;
        end
        if (code != hel_pkg::ERR_OK)
        begin
            phase = hel_pkg::PH_HALT;
            o = '0;
            o.action = hel_pkg::ACT_ERROR;
            o.error_code = code;
        end
        o.hunk_number = cur_hunk;
        return o;
    endfunction

    // sender: one beat per call, random idle ahead of it unless quiet
    task automatic send_word(logic [31:0] w, logic eof, bit typed = 0,
                             hel_pkg::out_t want = '0);
        hel_pkg::out_t exp_cmd;
        while (!quiet && $urandom_range(99) < 16)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item.file_word <= w;
        item.end_of_file <= eof;
        do @(posedge clk); while (item_stall);
        exp_cmd = next_command(w, eof);
        pending_cmds.push_back(typed ? want : exp_cmd);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        item_valid <= 1'b0;
        wait (pending_cmds.size() == 0);
        repeat (6) @(posedge clk);
        write_enable <= 1'b1;
        reg_index <= idx;
        write_data <= val;
        @(posedge clk);
        write_enable <= 1'b0;
        if (idx == hel_pkg::REG_LOAD_BASE) base_reg = val; else reloc_on = val[0];
        @(posedge clk);
    endtask

    task automatic send_hunk(bit last);
        int          n;
        int          groups;
        int          cnt;
        logic [1:0]  top;
        logic [29:0] id;
        top = 2'($urandom_range(3));
        case ($urandom_range(2))
            0: id = hel_pkg::ID_CODE;
            1: id = hel_pkg::ID_DATA;
            default: id = hel_pkg::ID_BSS;
        endcase
        send_word({top, id}, 1'b0);
        if (id == hel_pkg::ID_BSS)
            send_word($urandom(), 1'b0);
        else
        begin
            n = $urandom_range(24);
            send_word(n, 1'b0);
            repeat (n) send_word($urandom(), 1'b0);
        end
        if ($urandom_range(1))
        begin
            send_word({2'b00, hel_pkg::ID_RELOC32}, 1'b0);
            groups = $urandom_range(1, 4);
            repeat (groups)
            begin
                cnt = $urandom_range(1, 8);
                send_word(cnt, 1'b0);
                send_word($urandom_range(HUNKS - 1), 1'b0);
                repeat (cnt) send_word($urandom(), 1'b0);
            end
            send_word(32'd0, 1'b0);
        end
        send_word({2'($urandom_range(3)), hel_pkg::ID_END}, last);
    endtask

    // result side
    int hold_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_req && !hold_done && hold_left == 0)
        begin
            hold_done <= 1'b1;
            hold_left <= 300;
            result_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            result_stall <= (hold_left > 1);
        end
        else
            result_stall <= !quiet && ($urandom_range(99) < 16);
    end

    always @(posedge clk)
    begin
        hel_pkg::out_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_cmds.size() == 0)
            begin
                $error("result beat with nothing expected");
                fails++;
            end
            else
            begin
                want = pending_cmds.pop_front();
                if (result.action !== want.action)
                begin
                    $error("action exp %0d got %0d", want.action, result.action);
                    fails++;
                end
                if (result.target_address !== want.target_address)
                begin
                    $error("target_address exp %h got %h", want.target_address,
                           result.target_address);
                    fails++;
                end
                if (result.payload !== want.payload)
                begin
                    $error("payload exp %h got %h", want.payload, result.payload);
                    fails++;
                end
                if (result.error_code !== want.error_code)
                begin
                    $error("error_code exp %0d got %0d", want.error_code, result.error_code);
                    fails++;
                end
                if (result.hunk_number !== want.hunk_number)
                begin
                    $error("hunk_number exp %0d got %0d", want.hunk_number,
                           result.hunk_number);
                    fails++;
                end
            end
        end
    end

    // watchdog on stalled progress
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else if (rst_n)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("hunk_executable_loader: mismatch");
            $finish;
        end
    end

    row_t hdr[5];
    row_t body[$];

    initial
    begin
        hel_pkg::out_t idle_cmd;
        int   i;
        rst_n = 1'b0;
        write_enable = 1'b0;
        reg_index = hel_pkg::REG_LOAD_BASE;
        write_data = '0;
        item_valid = 1'b0;
        item = '0;
        quiet = 0;
        hold_req = 0;
        base_reg = '0;
        reloc_on = 0;
        phase = hel_pkg::PH_MAGIC;
        total_hunks = 0;
        fill_idx = 0;
        cur_hunk = 0;
        seen = 0;
        words_left = 0;
        store_ptr = 0;
        addend = 0;
        for (i = 0; i <= HUNKS; i++) hunk_addr[i] = '0;

        idle_cmd = '0;
        // header: 64 hunks, table size last+1
        hdr[0] = '{hel_pkg::ID_HEADER, 1'b0, 1'b1, idle_cmd};
        hdr[1] = '{32'd0, 1'b0, 1'b1, idle_cmd};
        hdr[2] = '{32'(HUNKS), 1'b0, 1'b1, idle_cmd};
        hdr[3] = '{32'd0, 1'b0, 1'b1, idle_cmd};
        hdr[4] = '{32'(HUNKS - 1), 1'b0, 1'b1, idle_cmd};
        // hunk 0: code with flag bits set, both data extremes, relocs at edges
        body = '{
            '{32'hC000_03E9, 1'b0, 1'b0, idle_cmd}, '{32'd2, 1'b0, 1'b0, idle_cmd},
            '{32'hFFFF_FFFF, 1'b0, 1'b0, idle_cmd}, '{32'h0000_0000, 1'b0, 1'b0, idle_cmd},
            '{32'h0000_03EC, 1'b0, 1'b0, idle_cmd}, '{32'd2, 1'b0, 1'b0, idle_cmd},
            '{32'd0, 1'b0, 1'b0, idle_cmd}, '{32'd0, 1'b0, 1'b0, idle_cmd},
            '{32'hFFFF_FFFC, 1'b0, 1'b0, idle_cmd}, '{32'd1, 1'b0, 1'b0, idle_cmd},
            '{32'(HUNKS - 1), 1'b0, 1'b0, idle_cmd}, '{32'd4, 1'b0, 1'b0, idle_cmd},
            '{32'd0, 1'b0, 1'b0, idle_cmd}, '{32'h0000_03F2, 1'b0, 1'b0, idle_cmd},
            // hunk 1: empty data block
            '{32'h4000_03EA, 1'b0, 1'b0, idle_cmd}, '{32'd0, 1'b0, 1'b0, idle_cmd},
            '{32'h0000_03F2, 1'b0, 1'b0, idle_cmd},
            // hunk 2: bss of maximal length
            '{32'h8000_03EB, 1'b0, 1'b0, idle_cmd}, '{32'hFFFF_FFFF, 1'b0, 1'b0, idle_cmd},
            '{32'h0000_03F2, 1'b0, 1'b0, idle_cmd}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_reg(hel_pkg::REG_LOAD_BASE, 32'hFFFF_FF00);
        write_reg(hel_pkg::REG_RELOC_ENABLE, 32'd1);

        foreach (hdr[k]) send_word(hdr[k].word, hdr[k].eof, hdr[k].typed, hdr[k].want);
        // size words: extremes first, then random with flags 0..2
        send_word(32'hBFFF_FFFF, 1'b0);
        send_word(32'h4000_0000, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        for (i = 3; i < HUNKS; i++)
            send_word({2'($urandom_range(2)), 30'($urandom_range(255))}, 1'b0);
        foreach (body[k]) send_word(body[k].word, body[k].eof);

        for (i = 3; i < HUNKS; i++)
        begin
            if (i % 8 == 0)
            begin
                // drain, then flip relocation output and move the base
                write_reg(hel_pkg::REG_RELOC_ENABLE, {31'd0, !reloc_on});
                write_reg(hel_pkg::REG_LOAD_BASE, (i == 16) ? 32'd0 :
                          (i == 24) ? 32'hFFFF_FFFF : $urandom());
            end
            if (i == 20) hold_req = 1;
            quiet = (i >= 30 && i < 40);
            send_hunk(i == HUNKS - 1);
        end
        quiet = 0;
        // halted: everything after answers none
        repeat (10) send_word($urandom(), 1'($urandom_range(1)));
        item_valid <= 1'b0;

        wait (pending_cmds.size() == 0);
        repeat (10) @(posedge clk);
        if (fails == 0)
            $display("hunk_executable_loader: match");
        else
            $display("hunk_executable_loader: mismatch");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/hel_pkg.sv
hw/rtl/hel_table.sv
hw/rtl/hel_parse.sv
hw/rtl/hel_emit.sv
hw/rtl/hunk_executable_loader.sv
hw/rtl/hel_checker.sv
verif/tb.sv
